// ===== design/biq_pkg.sv =====
package biq_pkg;

    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int COEF_FRAC_BITS_DEF = 20;

    // Width of a coefficient register write.
    localparam int COEF_BITS    = 24;
    localparam int NUM_COEFS    = 5;
    localparam int CFG_IDX_BITS = 3;

    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;

    // Register indexes of the configuration port.
    localparam t_cfg_idx CFG_B0 = 3'd0;
    localparam t_cfg_idx CFG_B1 = 3'd1;
    localparam t_cfg_idx CFG_B2 = 3'd2;
    localparam t_cfg_idx CFG_A1 = 3'd3;
    localparam t_cfg_idx CFG_A2 = 3'd4;

endpackage

// ===== design/biq_in_if.sv =====
interface biq_in_if #(
    parameter int SAMPLE_BITS = biq_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

// ===== design/biq_out_if.sv =====
interface biq_out_if #(
    parameter int SAMPLE_BITS = biq_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

// ===== design/biq_chan.sv =====
module biq_chan #(
    parameter int SAMPLE_BITS    = biq_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = biq_pkg::COEF_FRAC_BITS_DEF,
    parameter int CW             = biq_pkg::COEF_BITS
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_adv,
    input  logic signed [SAMPLE_BITS-1:0]                  i_x,
    input  logic [biq_pkg::NUM_COEFS-1:0][CW-1:0]          i_coef,
    output logic signed [SAMPLE_BITS-1:0]                  o_y
);
    import biq_pkg::*;

    localparam int PW = SAMPLE_BITS + CW;
    localparam int AW = PW + 3;

    localparam logic signed [AW-1:0] RND_HALF = AW'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [AW-1:0] Y_MAX =
        {{(AW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [AW-1:0] Y_MIN =
        {{(AW-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

    logic signed [SAMPLE_BITS-1:0] r_xh [2];
    logic signed [SAMPLE_BITS-1:0] r_yh [2];

    logic signed [PW-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
    logic signed [AW-1:0] acc, rnd, q;

    assign p_b0 = $signed(i_x)     * $signed(i_coef[CFG_B0]);
    assign p_b1 = $signed(r_xh[0]) * $signed(i_coef[CFG_B1]);
    assign p_b2 = $signed(r_xh[1]) * $signed(i_coef[CFG_B2]);
    assign p_a1 = $signed(r_yh[0]) * $signed(i_coef[CFG_A1]);
    assign p_a2 = $signed(r_yh[1]) * $signed(i_coef[CFG_A2]);

    assign acc = AW'(p_b0) + AW'(p_b1) + AW'(p_b2) - AW'(p_a1) - AW'(p_a2);
    // Round half up, then floor shift back to the sample grid.
    assign rnd = acc + RND_HALF;
    assign q   = rnd >>> COEF_FRAC_BITS;

    always_comb begin
        if (q > Y_MAX) begin
            o_y = Y_MAX[SAMPLE_BITS-1:0];
        end else if (q < Y_MIN) begin
            o_y = Y_MIN[SAMPLE_BITS-1:0];
        end else begin
            o_y = q[SAMPLE_BITS-1:0];
        end
    end

    // Shift histories; the saturated output is what feeds back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xh[0] <= '0;
            r_xh[1] <= '0;
            r_yh[0] <= '0;
            r_yh[1] <= '0;
        end else if (i_adv) begin
            r_xh[1] <= r_xh[0];
            r_xh[0] <= i_x;
            r_yh[1] <= r_yh[0];
            r_yh[0] <= o_y;
        end
    end
endmodule

// ===== design/stereo_biquad_iir_filter_unit.sv =====
// Stereo biquad filter, direct form I, one shared coefficient set.
//
// Input channel i_in carries one stereo frame (left_in, right_in) per
// transaction; output channel o_out returns one filtered frame (left_out,
// right_out) per input transaction, in order. Both use valid/ready. Coefficients
// b0, b1, b2, a1, a2 are written through i_cfg_we / i_cfg_idx / i_cfg_wdata
// (indexes 0..4, others ignored); writing only while idle is left to the user.
//
// Path: an accepted frame goes from the input register through the arithmetic
// stage into the output register. Throughput: one frame per cycle while o_out
// takes frames; the filter recursion closes inside the single arithmetic stage
// (ten parallel multiplies, sum, round, saturate) between the two registers.
// Reset: coefficients return to b0 = 1.0 (pass-through), all others 0;
// histories and both pipeline valids clear.
// Stall: while o_out is held, the output register keeps its frame and one
// more frame is still taken into the input register; further input waits.
module stereo_biquad_iir_filter_unit #(
    parameter int SAMPLE_BITS    = biq_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = biq_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    biq_in_if.sink                        i_in,
    biq_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  biq_pkg::t_cfg_idx             i_cfg_idx,
    input  logic [biq_pkg::COEF_BITS-1:0] i_cfg_wdata
);
    import biq_pkg::*;

    // Widen coefficient storage if 1.0 would not fit the write width.
    localparam int CW = (COEF_FRAC_BITS + 2 > COEF_BITS) ? COEF_FRAC_BITS + 2 : COEF_BITS;
    localparam logic [CW-1:0] B0_RST = CW'(1) << COEF_FRAC_BITS;

    logic [NUM_COEFS-1:0][CW-1:0] r_coef;

    logic                          r_s1_vld;
    logic signed [SAMPLE_BITS-1:0] r_s1_l, r_s1_r;
    logic                          r_o_vld;
    logic signed [SAMPLE_BITS-1:0] r_o_l, r_o_r;

    logic signed [SAMPLE_BITS-1:0] y_l, y_r;
    logic                          out_free, s1_adv, in_acc;

    // Coefficient registers: sign-extend each write to storage width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[CFG_B0] <= B0_RST;
            r_coef[CFG_B1] <= '0;
            r_coef[CFG_B2] <= '0;
            r_coef[CFG_A1] <= '0;
            r_coef[CFG_A2] <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_B0: r_coef[CFG_B0] <= CW'($signed(i_cfg_wdata));
                CFG_B1: r_coef[CFG_B1] <= CW'($signed(i_cfg_wdata));
                CFG_B2: r_coef[CFG_B2] <= CW'($signed(i_cfg_wdata));
                CFG_A1: r_coef[CFG_A1] <= CW'($signed(i_cfg_wdata));
                CFG_A2: r_coef[CFG_A2] <= CW'($signed(i_cfg_wdata));
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    // Handshake: the output register frees when empty or being drained;
    // the input register, when full, advances into it whenever it is free.
    assign out_free   = !r_o_vld || o_out.ready;
    assign s1_adv     = r_s1_vld && out_free;
    assign i_in.ready = !r_s1_vld || s1_adv;
    assign in_acc     = i_in.valid && i_in.ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_l <= i_in.left_in;
            r_s1_r <= i_in.right_in;
        end
    end

    // One filter section per channel; histories advance with the frame.
    biq_chan #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .CW             (CW)
    ) u_chan_l (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (s1_adv),
        .i_x     (r_s1_l),
        .i_coef  (r_coef),
        .o_y     (y_l)
    );

    biq_chan #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .CW             (CW)
    ) u_chan_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (s1_adv),
        .i_x     (r_s1_r),
        .i_coef  (r_coef),
        .o_y     (y_r)
    );

    // Output register: hold the frame until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (out_free) begin
            r_o_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_o_l <= y_l;
            r_o_r <= y_r;
        end
    end

    assign o_out.valid     = r_o_vld;
    assign o_out.left_out  = r_o_l;
    assign o_out.right_out = r_o_r;

    // A frame leaving the input register always lands in the output register.
    a_adv_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_o_vld)
        else $error("advancing frame lost before output register");

    // A full pipeline under stall keeps its pending frame.
    a_stall_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_o_vld && !o_out.ready) |=> r_s1_vld)
        else $error("pending frame dropped during output stall");

    // New input into an occupied stage only while that stage moves on.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_s1_vld) |-> s1_adv)
        else $error("input register overwritten");

    // Reset empties both pipeline registers.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_s1_vld && !r_o_vld))
        else $error("pipeline not empty after reset");
endmodule
